FILE: sv/bcb_pkg.sv
// ----------------------------------------------------------------------------
// bcb_pkg
// Shared types and constants for the byte concreteness bitmap unit.
// ----------------------------------------------------------------------------
package bcb_pkg;

   // operation codes carried on req_tuser
   localparam logic OP_CHECK = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // input field widths
   localparam int OFFSET_W = 10;
   localparam int COUNT_W  = 11;

   // offset + count never exceeds 3070, so byte positions fit in 12 bits
   localparam int BYTE_POS_W = 12;
   // with at least 8 bits per cell, a reachable cell index is below 384
   localparam int CELL_IDX_W = 9;
   // bit position inside a cell of at most 64 bits
   localparam int BIT_POS_W  = 6;

   typedef struct packed {
      logic                  op;
      logic                  mark_value;
      logic                  out_of_range;
      logic                  empty;
      logic [CELL_IDX_W-1:0] first_cell;
      logic [CELL_IDX_W-1:0] last_cell;
      logic [BIT_POS_W-1:0]  head_pos;
      logic [BIT_POS_W-1:0]  tail_pos;
   } cmd_type;

endpackage

FILE: sv/byte_concreteness_bitmap_unit.sv
// ----------------------------------------------------------------------------
// byte_concreteness_bitmap_unit
// One mark bit per byte of an object, checked or written over byte ranges.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | tuser: op; tdata: offset, count, mark
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata: all_concrete, out_of_range
//
//  A range covering n cells is walked cell by cell in the back end: the mark memory
//  gives one cell read and one cell write per cycle. Out-of-range and empty
//  ranges go straight to the response. Up to two classified transactions queue ahead.
//  After reset a clearing pass sets every cell, one per cycle, and
//  req_tready stays low meanwhile.
//  A response waiting on rsp_tready holds only the back end.
// ----------------------------------------------------------------------------
module byte_concreteness_bitmap_unit #(
   parameter int MAP_BYTES = 1024,
   parameter int CELL_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // op
   input  logic [23:0] req_tdata,   // byte_offset[9:0], byte_count[20:10], mark_value[21]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // all_concrete[0], out_of_range[1]
);
   import bcb_pkg::*;

   logic    hold;
   logic    q_full;
   logic    push_valid;
   cmd_type push_cmd;
   logic    q_valid;
   cmd_type q_cmd;
   logic    pop;

   bcb_front #(
      .MAP_BYTES(MAP_BYTES),
      .CELL_BITS(CELL_BITS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .hold       (hold),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   bcb_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .q_full     (q_full),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .pop        (pop)
   );

   bcb_back #(
      .MAP_BYTES(MAP_BYTES),
      .CELL_BITS(CELL_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .pop        (pop),
      .hold       (hold),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: sv/bcb_front.sv
// ----------------------------------------------------------------------------
// bcb_front
// Accepts request transactions, checks the range against the map and
// splits it into first and last cell with edge bit positions.
// ----------------------------------------------------------------------------
module bcb_front #(
   parameter int MAP_BYTES = 1024,
   parameter int CELL_BITS = 64
) (
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic                        req_tuser,
   input  logic [23:0]                 req_tdata,
   input  logic                        hold,
   input  logic                        q_full,
   output logic                        push_valid,
   output bcb_pkg::cmd_type            push_cmd
);
   import bcb_pkg::*;

   // reciprocal division by the cell size, exact for every 12-bit position
   localparam int DivShift = BYTE_POS_W + $clog2(CELL_BITS);
   localparam int Recip    = ((1 << DivShift) + CELL_BITS - 1) / CELL_BITS;
   localparam int ProdW    = BYTE_POS_W + DivShift + 1;

   logic [OFFSET_W-1:0]   byte_offset;
   logic [COUNT_W-1:0]    byte_count;
   logic                  mark_value;
   logic [BYTE_POS_W-1:0] end_pos;
   logic [BYTE_POS_W-1:0] last_pos;
   logic [ProdW-1:0]      first_prod;
   logic [ProdW-1:0]      last_prod;
   logic [BYTE_POS_W-1:0] first_q;
   logic [BYTE_POS_W-1:0] last_q;
   logic [BYTE_POS_W-1:0] first_r;
   logic [BYTE_POS_W-1:0] last_r;

   assign byte_offset = req_tdata[9:0];
   assign byte_count  = req_tdata[20:10];
   assign mark_value  = req_tdata[21];

   assign end_pos  = BYTE_POS_W'(byte_offset) + BYTE_POS_W'(byte_count);
   assign last_pos = end_pos - BYTE_POS_W'(1);

   assign first_prod = ProdW'(byte_offset) * ProdW'(Recip);
   assign last_prod  = ProdW'(last_pos) * ProdW'(Recip);
   assign first_q    = BYTE_POS_W'(first_prod >> DivShift);
   assign last_q     = BYTE_POS_W'(last_prod >> DivShift);
   assign first_r    = BYTE_POS_W'(byte_offset) - first_q * BYTE_POS_W'(CELL_BITS);
   assign last_r     = last_pos - last_q * BYTE_POS_W'(CELL_BITS);

   assign req_tready = !q_full && !hold;
   assign push_valid = req_tvalid && req_tready;

   always_comb begin
      push_cmd              = '0;
      push_cmd.op           = req_tuser;
      push_cmd.mark_value   = mark_value;
      push_cmd.out_of_range = 32'(end_pos) > 32'(MAP_BYTES);
      push_cmd.empty        = (byte_count == '0);
      push_cmd.first_cell   = CELL_IDX_W'(first_q);
      push_cmd.last_cell    = CELL_IDX_W'(last_q);
      push_cmd.head_pos     = BIT_POS_W'(first_r);
      push_cmd.tail_pos     = BIT_POS_W'(last_r);
   end

endmodule

FILE: sv/bcb_cmd_queue.sv
// ----------------------------------------------------------------------------
// bcb_cmd_queue
// Two-entry queue of classified commands between front and back.
// ----------------------------------------------------------------------------
module bcb_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   input  bcb_pkg::cmd_type push_cmd,
   output logic             q_full,
   output logic             q_valid,
   output bcb_pkg::cmd_type q_cmd,
   input  logic             pop
);
   import bcb_pkg::*;

   cmd_type     entry_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        do_push;
   logic        do_pop;

   assign q_full  = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_cmd   = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && !q_full;
   assign do_pop  = pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: sv/bcb_back.sv
// ----------------------------------------------------------------------------
// bcb_back
// Holds the mark cells in a memory and walks a command's cells one per
// cycle, checking or updating masked bits, then issues the response.
// ----------------------------------------------------------------------------
module bcb_back #(
   parameter int MAP_BYTES = 1024,
   parameter int CELL_BITS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_valid,
   input  bcb_pkg::cmd_type q_cmd,
   output logic             pop,
   output logic             hold,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [7:0]       rsp_tdata
);
   import bcb_pkg::*;

   localparam int CellCount = (MAP_BYTES + CELL_BITS - 1) / CELL_BITS;
   localparam int AddrW     = (CellCount > 1) ? $clog2(CellCount) : 1;
   localparam logic [AddrW-1:0] LastCell = AddrW'(CellCount - 1);
   localparam logic [CELL_BITS-1:0] Ones = {CELL_BITS{1'b1}};

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RUN   = 2'd2;
   localparam logic [1:0] ST_DONE  = 2'd3;

   logic [CELL_BITS-1:0]  mem_ff [CellCount];
   logic [CELL_BITS-1:0]  rdata_ff;

   logic [1:0]            state_ff, state_in;
   cmd_type               cmd_ff, cmd_in;
   logic [CELL_IDX_W-1:0] rd_cell_ff, rd_cell_in;
   logic [CELL_IDX_W-1:0] proc_cell_ff, proc_cell_in;
   logic                  rd_done_ff, rd_done_in;
   logic                  all_ff, all_in;
   logic [AddrW-1:0]      clr_addr_ff, clr_addr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_all_ff, rsp_all_in;
   logic                  rsp_oor_ff, rsp_oor_in;

   logic                  rd_en;
   logic [AddrW-1:0]      rd_addr;
   logic                  wr_en;
   logic [AddrW-1:0]      wr_addr;
   logic [CELL_BITS-1:0]  wr_data;
   logic [BIT_POS_W-1:0]  lo_shift;
   logic [BIT_POS_W:0]    hi_shift;
   logic [CELL_BITS-1:0]  mask;
   logic                  slot_free;

   assign hold       = (state_ff == ST_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_oor_ff, rsp_all_ff};
   assign slot_free  = !rsp_valid_ff || rsp_tready;

   // edge masks: byte 0 of a cell sits in the top bit
   always_comb begin
      lo_shift = (proc_cell_ff == cmd_ff.first_cell) ? cmd_ff.head_pos : '0;
      hi_shift = (proc_cell_ff == cmd_ff.last_cell)
                 ? ((BIT_POS_W + 1)'(cmd_ff.tail_pos) + (BIT_POS_W + 1)'(1))
                 : (BIT_POS_W + 1)'(CELL_BITS);
      mask     = (Ones >> lo_shift) & ~(Ones >> hi_shift);
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      rd_cell_in   = rd_cell_ff;
      proc_cell_in = proc_cell_ff;
      rd_done_in   = rd_done_ff;
      all_in       = all_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_all_in   = rsp_all_ff;
      rsp_oor_in   = rsp_oor_ff;
      pop          = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = AddrW'(rd_cell_ff);
      wr_en        = 1'b0;
      wr_addr      = AddrW'(proc_cell_ff);
      wr_data      = rdata_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_addr_ff;
            wr_data = Ones;
            if (clr_addr_ff == LastCell) begin
               state_in = ST_IDLE;
            end else begin
               clr_addr_in = clr_addr_ff + AddrW'(1);
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               pop    = 1'b1;
               cmd_in = q_cmd;
               all_in = 1'b1;
               if (q_cmd.out_of_range || q_cmd.empty) begin
                  state_in = ST_DONE;
               end else begin
                  rd_en        = 1'b1;
                  rd_addr      = AddrW'(q_cmd.first_cell);
                  proc_cell_in = q_cmd.first_cell;
                  rd_cell_in   = q_cmd.first_cell + CELL_IDX_W'(1);
                  rd_done_in   = (q_cmd.first_cell == q_cmd.last_cell);
                  state_in     = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            // rdata_ff holds the cell at proc_cell_ff
            if (cmd_ff.op == OP_WRITE) begin
               wr_en   = 1'b1;
               wr_data = cmd_ff.mark_value ? (rdata_ff | mask) : (rdata_ff & ~mask);
            end else begin
               all_in = all_ff && ((rdata_ff & mask) == mask);
            end
            if (rd_done_ff) begin
               state_in = ST_DONE;
            end else begin
               rd_en        = 1'b1;
               proc_cell_in = rd_cell_ff;
               rd_cell_in   = rd_cell_ff + CELL_IDX_W'(1);
               rd_done_in   = (rd_cell_ff == cmd_ff.last_cell);
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_all_in   = (cmd_ff.op == OP_CHECK) && !cmd_ff.out_of_range && all_ff;
               rsp_oor_in   = cmd_ff.out_of_range;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rd_done_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rd_done_ff   <= rd_done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      rd_cell_ff   <= rd_cell_in;
      proc_cell_ff <= proc_cell_in;
      all_ff       <= all_in;
      rsp_all_ff   <= rsp_all_in;
      rsp_oor_ff   <= rsp_oor_in;
   end

   // mark cell memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem_ff[rd_addr];
      end
   end

endmodule
